FILE: rtl/cfp_pkg.sv
// shared types, constants and float helpers for the clamped float power block
`timescale 1ns / 1ps
package cfp_pkg;

  localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
  localparam logic [31:0] CLAMP_RESET  = 32'h4085_C28F;
  localparam logic [31:0] DEFAULT_NAN  = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
  localparam int          PROD_W       = 48;
  localparam int          LZ_W         = 6;
  localparam int          EXP_W        = 31;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,
    ST_CHECK = 7'b000_0010,
    ST_MUL1  = 7'b000_0100,
    ST_MUL2  = 7'b000_1000,
    ST_SQ1   = 7'b001_0000,
    ST_SQ2   = 7'b010_0000,
    ST_FIN   = 7'b100_0000
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_sel_acc;
    logic wb_acc;
    logic wb_sq;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic y_zero;
    logic y_lsb;
    logic out_busy;
  } status_t;

  function automatic logic fp_is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // leading zero count of a nonzero product
  function automatic logic [LZ_W-1:0] lzc48(input logic [PROD_W-1:0] p);
    logic [LZ_W-1:0] n;
    logic            found;
    n     = '0;
    found = 1'b0;
    for (int i = PROD_W - 1; i >= 0; i--) begin
      if (!found && p[i]) begin
        found = 1'b1;
        n     = LZ_W'(PROD_W - 1 - i);
      end
    end
    return n;
  endfunction

  // ordered key for float compare, ignoring nan and signed zero
  function automatic logic [31:0] fp_key(input logic [31:0] b);
    return b[31] ? ~b : {1'b1, b[30:0]};
  endfunction

  function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
    logic both_zero;
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    return !fp_is_nan(a) && !fp_is_nan(b) && !both_zero && (fp_key(a) > fp_key(b));
  endfunction

endpackage

FILE: rtl/cfp_ctrl.sv
// controller state machine for the square-and-multiply sequence
`timescale 1ns / 1ps
module cfp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cfp_pkg::status_t status_i,
  output cfp_pkg::cmd_t    cmd_o
);
  import cfp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.y_zero) begin
          state_d = ST_FIN;
        end else if (status_i.y_lsb) begin
          state_d = ST_MUL1;
        end else begin
          state_d = ST_SQ1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul_start   = 1'b1;
        cmd_o.mul_sel_acc = 1'b1;
        state_d           = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.wb_acc = 1'b1;
        state_d      = ST_SQ1;
      end
      ST_SQ1: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_SQ2;
      end
      ST_SQ2: begin
        cmd_o.wb_sq = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/cfp_datapath.sv
// operand registers, two-stage binary32 multiplier, clamp and output register
`timescale 1ns / 1ps
module cfp_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfp_pkg::cmd_t    cmd_i,
  output cfp_pkg::status_t status_o,
  input  logic [31:0]      base_bits_i,
  input  logic [31:0]      exponent_i,
  input  logic             last_in_i,
  input  logic [31:0]      clamp_bits_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      result_bits_o,
  output logic             last_out_o
);
  import cfp_pkg::*;

  logic [31:0]       acc_q, sq_q;
  logic [EXP_W-1:0]  y_q;
  logic              last_q;
  logic              out_valid_q;
  logic [31:0]       res_q;
  logic              res_last_q;

  // multiplier stage one registers
  logic [PROD_W-1:0] p_q;
  logic [8:0]        esum_q;
  logic              sign_q;
  logic              spec_q;
  logic [31:0]       spec_val_q;

  // stage one: unpack, specials, mantissa product
  logic [31:0] op_a, op_b;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s_sign;
  logic [23:0] ma, mb;
  logic [7:0]  eva, evb;
  logic        spec_d;
  logic [31:0] spec_val_d;

  always_comb begin
    op_a   = cmd_i.mul_sel_acc ? acc_q : sq_q;
    op_b   = sq_q;
    a_nan  = fp_is_nan(op_a);
    b_nan  = fp_is_nan(op_b);
    a_inf  = (op_a[30:23] == 8'hFF) && (op_a[22:0] == 23'd0);
    b_inf  = (op_b[30:23] == 8'hFF) && (op_b[22:0] == 23'd0);
    a_zero = (op_a[30:0] == 31'd0);
    b_zero = (op_b[30:0] == 31'd0);
    s_sign = op_a[31] ^ op_b[31];
    ma     = {(op_a[30:23] != 8'd0), op_a[22:0]};
    mb     = {(op_b[30:23] != 8'd0), op_b[22:0]};
    eva    = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
    evb    = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
    spec_d     = 1'b1;
    spec_val_d = {s_sign, 31'd0};
    if (a_nan) begin
      spec_val_d = op_a | QUIET_BIT;
    end else if (b_nan) begin
      spec_val_d = op_b | QUIET_BIT;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      spec_val_d = DEFAULT_NAN;
    end else if (a_inf || b_inf) begin
      spec_val_d = {s_sign, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      spec_val_d = {s_sign, 31'd0};
    end else begin
      spec_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      p_q        <= ma * mb;
      esum_q     <= {1'b0, eva} + {1'b0, evb};
      sign_q     <= s_sign;
      spec_q     <= spec_d;
      spec_val_q <= spec_val_d;
    end
  end

  // stage two: normalise, denormalise, round
  logic [LZ_W-1:0]   lz;
  logic signed [10:0] er, shn;
  logic [LZ_W-1:0]   sh;
  logic [PROD_W-1:0] pn, t, mask;
  logic              lost, g, st, inc;
  logic [23:0]       m24;
  logic [9:0]        eb;
  logic [32:0]       sum;
  logic [31:0]       prod;

  always_comb begin
    lz   = lzc48(p_q);
    er   = $signed({2'b00, esum_q}) - 11'sd126 - $signed({5'd0, lz});
    shn  = 11'sd1 - er;
    pn   = p_q << lz;
    if (er > 11'sd0) begin
      sh = '0;
    end else if (shn > 11'sd47) begin
      sh = LZ_W'(PROD_W);
    end else begin
      sh = shn[LZ_W-1:0];
    end
    t    = pn >> sh;
    mask = ~({PROD_W{1'b1}} << sh);
    lost = |(pn & mask);
    m24  = t[47:24];
    g    = t[23];
    st   = (|t[22:0]) | lost;
    inc  = g & (st | m24[0]);
    eb   = (er > 11'sd0) ? 10'(er - 11'sd1) : 10'd0;
    sum  = {eb, 23'd0} + 33'({1'b0, m24} + 25'(inc));
    if (sum[32:23] >= 10'd255) begin
      prod = {sign_q, 8'hFF, 23'd0};
    end else begin
      prod = {sign_q, sum[30:0]};
    end
    if (spec_q) begin
      prod = spec_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q  <= ONE_BITS;
      sq_q   <= base_bits_i;
      y_q    <= exponent_i[31] ? '0 : exponent_i[30:0];
      last_q <= last_in_i;
    end else begin
      if (cmd_i.wb_acc) begin
        acc_q <= prod;
      end
      if (cmd_i.wb_sq) begin
        sq_q <= prod;
        y_q  <= y_q >> 1;
      end
    end
    if (cmd_i.fin) begin
      res_q      <= fp_gt(acc_q, clamp_bits_i) ? clamp_bits_i : acc_q;
      res_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.y_zero   = (y_q == '0);
  assign status_o.y_lsb    = y_q[0];
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign result_bits_o     = res_q;
  assign last_out_o        = res_last_q;

endmodule

FILE: rtl/clamped_float_power.sv
// top level of the clamped binary32 integer power block
`timescale 1ns / 1ps
// channel    | dir | payload
// -----------+-----+------------------------------------------------------
// s_axis     | in  | tdata[31:0] base_bits, tdata[63:32] exponent, tlast
// m_axis     | out | tdata[31:0] result_bits, tlast
// cfg        | in  | cfg_data_i clamp_bits, always ready
//
// an item steps through the bits of a positive exponent (up to 31 bits),
// squaring for every bit and multiplying into the result for every set bit;
// every step goes through the one shared two-stage multiplier
// reset loads the clamp with 4.18 and empties the output register
// a held result stalls the next item only at its final clamp step
module clamped_float_power (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // base_bits, exponent
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_bits
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import cfp_pkg::*;

  logic [31:0] clamp_q;
  cmd_t        cmd;
  status_t     status;

  // clamp register, writable at any time the block is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= CLAMP_RESET;
    end else if (cfg_valid_i) begin
      clamp_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  cfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cfp_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .base_bits_i   (s_axis_tdata[31:0]),
    .exponent_i    (s_axis_tdata[63:32]),
    .last_in_i     (s_axis_tlast),
    .clamp_bits_i  (clamp_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_bits_o (m_axis_tdata),
    .last_out_o    (m_axis_tlast)
  );

  // one item in flight: no second accept straight after the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // a new result only appears right after a step with the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a finishing step");

endmodule

FILE: tb/sv/tb_clamped_float_power.sv
// testbench for the clamped binary32 integer power block
`timescale 1ns / 1ps
module tb_clamped_float_power;
  import cfp_pkg::*;

  localparam logic [31:0] POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] NEG_INF  = 32'hFF80_0000;
  localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] MAX_NORM = 32'h7F7F_FFFF;
  localparam logic [31:0] MIN_SUB  = 32'h0000_0001;
  localparam logic [31:0] SNAN     = 32'h7F80_0001;
  localparam logic [31:0] QNAN_NEG = 32'hFFC1_2345;
  localparam logic [31:0] HALF     = 32'h3F00_0000;
  localparam logic [31:0] TWO      = 32'h4000_0000;

  typedef struct {
    logic [31:0] result_bits;
    logic        last_out;
  } power_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // base_bits, exponent
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // result_bits
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  power_result_t pending_results[$];
  logic [31:0]   clamp_model = CLAMP_RESET;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            recv_hold_cycles = 0;
  int            mismatches = 0;

  clamped_float_power i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("** clamped_float_power: FAILED **");
    $finish;
  end

  function automatic logic is_nan32(logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 0);
  endfunction

  // binary32 multiply, round to nearest even, x86 style nan handling
  function automatic logic [31:0] fmul32(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic [63:0] prod, rem, half_ulp, mant;
    int          ea, eb, pos, e, sh;
    sgn = a[31] ^ b[31];
    if (is_nan32(a)) return a | 32'h0040_0000;
    if (is_nan32(b)) return b | 32'h0040_0000;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:0] == 0 || b[30:0] == 0) return 32'hFFC0_0000;
      return {sgn, 31'h7F80_0000};
    end
    if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
    ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
    prod = 64'({a[30:23] != 0, a[22:0]}) * 64'({b[30:23] != 0, b[22:0]});
    pos = 0;
    for (int i = 0; i < 48; i++) if (prod[i]) pos = i;
    // value is prod * 2^(ea+eb-300), target mant * 2^(e-150)
    e = pos + ea + eb - 173;
    if (e < 1) e = 1;
    sh = e - ea - eb + 150;
    if (sh <= 0) begin
      mant = prod << (-sh);
    end else if (sh > 60) begin
      mant = 0;
    end else begin
      mant = prod >> sh;
      rem = prod & ((64'd1 << sh) - 1);
      half_ulp = 64'd1 << (sh - 1);
      if (rem > half_ulp || (rem == half_ulp && mant[0])) mant = mant + 1;
    end
    if (mant >= 64'h100_0000) begin
      mant = mant >> 1;
      e = e + 1;
    end
    if (e >= 255) return {sgn, 31'h7F80_0000};
    if (mant < 64'h80_0000) return {sgn, 8'd0, mant[22:0]};
    return {sgn, 8'(e), mant[22:0]};
  endfunction

  // strict float greater-than, false on any nan and on two zeros
  function automatic logic float_above(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka, kb;
    if (is_nan32(a) || is_nan32(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka > kb;
  endfunction

  function automatic logic [31:0] clamped_power(logic [31:0] base, logic [31:0] expo);
    logic [31:0] acc, sq, y;
    acc = ONE_BITS;
    sq  = base;
    if (!expo[31]) begin
      y = expo;
      while (y != 0) begin
        if (y[0]) acc = fmul32(acc, sq);
        sq = fmul32(sq, sq);
        y  = y >> 1;
      end
    end
    return float_above(acc, clamp_model) ? clamp_model : acc;
  endfunction

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk_i) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    power_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata !== exp_r.result_bits || m_axis_tlast !== exp_r.last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h last %b, got %h last %b",
                     exp_r.result_bits, exp_r.last_out, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  task automatic send_power(logic [31:0] base, logic [31:0] expo, logic last);
    power_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {expo, base};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r.result_bits = clamped_power(base, expo);
    r.last_out    = last;
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_clamp(logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    clamp_model = v;
  endtask

  function automatic logic [31:0] pick_base();
    case ($urandom_range(9))
      0, 1, 2, 3: return {1'($urandom_range(1)), 8'(126 + $urandom_range(1)), 23'($urandom)};
      4:       return {1'($urandom_range(1)), 8'(120 + $urandom_range(15)), 23'($urandom)};
      5:       return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
      6: begin
        case ($urandom_range(5))
          0: return POS_INF;
          1: return NEG_INF;
          2: return SNAN;
          3: return QNAN_NEG;
          4: return NEG_ZERO;
          default: return 32'd0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(12);
      5, 6:    return $urandom_range(255);
      7:       return 32'($urandom_range(1, 1000)) * -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_power(TWO, 32'd0, 1'b0);
    send_power(TWO, 32'h8000_0000, 1'b0);
    send_power(TWO, 32'hFFFF_FFFF, 1'b0);
    send_power(TWO, 32'd1, 1'b0);
    send_power(TWO, 32'd2, 1'b0);             // just below the clamp
    send_power(32'hC000_0000, 32'd3, 1'b0);   // negative result
    send_power(32'h3F80_0001, 32'h7FFF_FFFF, 1'b0);
    send_power(MAX_NORM, 32'd2, 1'b0);        // overflow to infinity, then clamped
    send_power(MIN_SUB, 32'd1, 1'b0);
    send_power(MIN_SUB, 32'd2, 1'b0);         // underflow to zero
    send_power(32'h1F80_0000, 32'd3, 1'b0);   // cube underflows to zero
    send_power(POS_INF, 32'd1, 1'b0);
    send_power(NEG_INF, 32'd3, 1'b0);
    send_power(NEG_ZERO, 32'd5, 1'b0);
    send_power(32'd0, 32'd4, 1'b0);
    send_power(SNAN, 32'd1, 1'b0);            // nan passes unclamped
    send_power(QNAN_NEG, 32'd6, 1'b0);
    send_power(32'hFFFF_FFFF, 32'd2, 1'b0);
    send_power(32'h3FB5_04F3, 32'd7, 1'b1);
    drain_results();
    // clamp below one replaces a nonpositive exponent result
    write_clamp(HALF);
    send_power(32'h4049_0FDB, 32'd0, 1'b0);
    send_power(32'h3E80_0000, 32'd1, 1'b1);
    drain_results();
    // nan clamp never clamps
    write_clamp(32'h7FC0_0000);
    send_power(POS_INF, 32'd1, 1'b0);
    send_power(TWO, 32'd9, 1'b1);
    drain_results();
  endtask

  task automatic test_random(int n, logic [31:0] clamp);
    write_clamp(clamp);
    for (int i = 0; i < n; i++)
      send_power(pick_base(), pick_exponent(), (i % 16 == 15) || (i == n - 1));
    drain_results();
  endtask

  // long receiver hold-off so the block backs up into its input
  task automatic test_backpressure();
    write_clamp(CLAMP_RESET);
    @(posedge clk_i);
    recv_hold_cycles = 400;
    for (int i = 0; i < 20; i++)
      send_power(pick_base(), $urandom_range(20), i == 19);
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 24;
    recv_idle_pct = 47;
    test_random(130, CLAMP_RESET);
    test_random(120, 32'd0);
    test_random(120, POS_INF);
    send_idle_pct = 47;
    recv_idle_pct = 24;
    test_random(120, 32'hFFFF_FFFF);
    test_random(120, $urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(110, ONE_BITS);
    test_backpressure();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** clamped_float_power: PASSED **");
    end else begin
      $display("** clamped_float_power: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cfp_pkg.sv
rtl/cfp_ctrl.sv
rtl/cfp_datapath.sv
rtl/clamped_float_power.sv
tb/sv/tb_clamped_float_power.sv
